/* rtl/core/hcd_pkg.sv */
// Shared types and constants for the Harris corner detector.
package hcd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int SIZE_W  = 11;                      // frame size register width
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int SLOT_W  = 2;                       // four row slots in each line store
  localparam int ADDR_W  = SLOT_W + COL_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;
  localparam int POS_W   = SIZE_W + 2;              // signed coordinate width
  localparam int K_W     = 21;                      // raster count width
  localparam int PIX_W   = 8;
  localparam int GRAD_W  = 11;                      // one Sobel component
  localparam int GPAIR_W = 2 * GRAD_W;
  localparam int THR_W   = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EIGEN_THR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESP_THR     = 3'd3;

  // Item codes
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef struct packed {
    logic             func;
    logic [PIX_W-1:0] pixel;
  } in_t;

  typedef struct packed {
    logic             valid_res;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             is_corner;
    logic             last;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_START, S_CHK, S_GRD, S_GRD_END, S_GWR,
    S_WIN, S_WIN_M, S_WIN_A, S_D1, S_D2, S_D3, S_D4, S_OUT
  } state_t;

endpackage

/* rtl/core/hcd_ram.sv */
// Generic simple dual-port RAM with registered read.
module hcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/harris_corner_detector_top.sv */
// Harris corner detector top level: line stores, Sobel and tensor sequencer.
//
// Pixels enter on in_* (valid/ready) in raster order, one request per pixel;
// func marks a drain request. Each request yields exactly one result on
// out_* (valid/ready). The result for raster position q comes with request
// q + 2*W + 2, so a frame needs W*H pixel requests then 2*W + 2 drains.
// Results with valid_res low carry all-zero fields.
//
// One request is worked at a time: a 9-read sweep of the pixel line store
// builds the Sobel gradient, a 9-read sweep of the gradient line store
// builds the structure tensor sums, and four multiply steps decide the
// corner. Both line stores are one-read, one-write RAMs, which set the
// sweep lengths. Requests that give no decided position skip the tensor
// sweep.
//
// Synchronous reset clears the raster count, the registers to their
// defaults and the output. If the receiver stalls, the result waits in the
// output register; the next request is still taken, but its result waits.
// Configuration writes via cfg_we/cfg_index/cfg_data take effect at once.
module harris_corner_detector_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  hcd_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output hcd_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  logic [hcd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hcd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int PW = hcd_pkg::POS_W;

  // Configuration registers
  logic [hcd_pkg::SIZE_W-1:0] fw, fh;
  logic [hcd_pkg::THR_W-1:0]  thr_e, thr_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      fw    <= hcd_pkg::SIZE_W'(640);
      fh    <= hcd_pkg::SIZE_W'(480);
      thr_e <= hcd_pkg::THR_W'(183400);
      thr_r <= hcd_pkg::THR_W'(183400);
    end else if (cfg_we) begin
      case (cfg_index)
        hcd_pkg::REG_FRAME_WIDTH:  fw    <= cfg_data[hcd_pkg::SIZE_W-1:0];
        hcd_pkg::REG_FRAME_HEIGHT: fh    <= cfg_data[hcd_pkg::SIZE_W-1:0];
        hcd_pkg::REG_EIGEN_THR:    thr_e <= cfg_data[hcd_pkg::THR_W-1:0];
        hcd_pkg::REG_RESP_THR:     thr_r <= cfg_data[hcd_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped frame size
  logic [hcd_pkg::SIZE_W-1:0] wc, hc;
  always_comb begin
    if (fw < hcd_pkg::SIZE_W'(3)) wc = hcd_pkg::SIZE_W'(3);
    else if (fw > hcd_pkg::SIZE_W'(hcd_pkg::MAX_WIDTH)) wc = hcd_pkg::SIZE_W'(hcd_pkg::MAX_WIDTH);
    else wc = fw;
    if (fh < hcd_pkg::SIZE_W'(3)) hc = hcd_pkg::SIZE_W'(3);
    else if (fh > hcd_pkg::SIZE_W'(hcd_pkg::MAX_HEIGHT)) hc = hcd_pkg::SIZE_W'(hcd_pkg::MAX_HEIGHT);
    else hc = fh;
  end

  hcd_pkg::state_t state, state_next;

  // Request and raster state
  logic                        func;
  logic [hcd_pkg::PIX_W-1:0]   pix;
  logic [hcd_pkg::K_W-1:0]     k, total, frame_end;
  logic [hcd_pkg::SIZE_W-1:0]  krow, kcol;
  logic                        noadv, res_live;
  logic [1:0]                  wi, wj;
  logic [1:0]                  ti, tj;
  logic                        glive, wlive, plive;

  // Datapath registers
  logic signed [11:0]          dx_acc, dy_acc;
  logic signed [21:0]          pxx, pyy, pxy;
  logic [23:0]                 a_acc, c_acc;
  logic signed [24:0]          b_acc;
  logic signed [51:0]          pe, bb;
  logic [24:0]                 tr;
  logic                        t1, t2, corner;
  logic [47:0]                 ac;
  logic signed [55:0]          det;
  logic [49:0]                 trsq;

  // Memory ports
  logic                          pix_we, grad_we;
  logic [hcd_pkg::ADDR_W-1:0]    pix_waddr, rd_addr, grad_waddr;
  logic [hcd_pkg::PIX_W-1:0]     pix_rdata;
  logic [hcd_pkg::GPAIR_W-1:0]   grad_rdata;

  // Coordinates of the gradient and the decided position for this request
  logic signed [PW-1:0] krow_s, kcol_s, w_s, h_s;
  logic signed [PW-1:0] gr, gc, qr, qc, rd_row, rd_col;
  logic                 gvalid, qvalid, pix_due, in_img;

  always_comb begin
    krow_s = $signed({2'b00, krow});
    kcol_s = $signed({2'b00, kcol});
    w_s    = $signed({2'b00, wc});
    h_s    = $signed({2'b00, hc});
    if (kcol != '0) begin
      gr = krow_s - PW'(1);
      gc = kcol_s - PW'(1);
    end else begin
      gr = krow_s - PW'(2);
      gc = w_s - PW'(1);
    end
    if (kcol >= hcd_pkg::SIZE_W'(2)) begin
      qr = krow_s - PW'(2);
      qc = kcol_s - PW'(2);
    end else begin
      qr = krow_s - PW'(3);
      qc = kcol_s + w_s - PW'(2);
    end
    gvalid  = (gr >= 0) && (gr < h_s);
    qvalid  = (qr >= 0) && (qr < h_s);
    pix_due = k < total;
  end

  // Read coordinates: reflected Sobel taps or clipped tensor window
  always_comb begin
    if (state == hcd_pkg::S_GRD) begin
      case (wi)
        2'd0:    rd_row = (gr == 0) ? PW'(1) : gr - PW'(1);
        2'd1:    rd_row = gr;
        default: rd_row = (gr + PW'(1) >= h_s) ? h_s - PW'(2) : gr + PW'(1);
      endcase
      case (wj)
        2'd0:    rd_col = (gc == 0) ? PW'(1) : gc - PW'(1);
        2'd1:    rd_col = gc;
        default: rd_col = (gc + PW'(1) >= w_s) ? w_s - PW'(2) : gc + PW'(1);
      endcase
    end else begin
      rd_row = qr - PW'(1) + $signed({{(PW-2){1'b0}}, wi});
      rd_col = qc - PW'(1) + $signed({{(PW-2){1'b0}}, wj});
    end
    in_img  = (rd_row >= 0) && (rd_row < h_s) && (rd_col >= 0) && (rd_col < w_s);
    rd_addr = {rd_row[hcd_pkg::SLOT_W-1:0], rd_col[hcd_pkg::COL_W-1:0]};
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      hcd_pkg::S_IDLE:    if (in_valid) state_next = hcd_pkg::S_SETUP;
      hcd_pkg::S_SETUP:   state_next = hcd_pkg::S_START;
      hcd_pkg::S_START:   state_next = hcd_pkg::S_CHK;
      hcd_pkg::S_CHK: begin
        if (pix_due && func == hcd_pkg::FUNC_DRAIN) state_next = hcd_pkg::S_OUT;
        else if (gvalid) state_next = hcd_pkg::S_GRD;
        else if (qvalid) state_next = hcd_pkg::S_WIN;
        else state_next = hcd_pkg::S_OUT;
      end
      hcd_pkg::S_GRD:     if (wi == 2'd2 && wj == 2'd2) state_next = hcd_pkg::S_GRD_END;
      hcd_pkg::S_GRD_END: state_next = hcd_pkg::S_GWR;
      hcd_pkg::S_GWR:     state_next = qvalid ? hcd_pkg::S_WIN : hcd_pkg::S_OUT;
      hcd_pkg::S_WIN:     if (wi == 2'd2 && wj == 2'd2) state_next = hcd_pkg::S_WIN_M;
      hcd_pkg::S_WIN_M:   state_next = hcd_pkg::S_WIN_A;
      hcd_pkg::S_WIN_A:   state_next = hcd_pkg::S_D1;
      hcd_pkg::S_D1:      state_next = hcd_pkg::S_D2;
      hcd_pkg::S_D2:      state_next = hcd_pkg::S_D3;
      hcd_pkg::S_D3:      state_next = hcd_pkg::S_D4;
      hcd_pkg::S_D4:      state_next = hcd_pkg::S_OUT;
      hcd_pkg::S_OUT:     if (!out_valid || out_ready) state_next = hcd_pkg::S_IDLE;
      default:            state_next = hcd_pkg::S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready   = (state == hcd_pkg::S_IDLE);
    pix_we     = (state == hcd_pkg::S_CHK) && pix_due && (func == hcd_pkg::FUNC_PIXEL);
    pix_waddr  = {krow[hcd_pkg::SLOT_W-1:0], kcol[hcd_pkg::COL_W-1:0]};
    grad_we    = (state == hcd_pkg::S_GWR);
    grad_waddr = {gr[hcd_pkg::SLOT_W-1:0], gc[hcd_pkg::COL_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) state <= hcd_pkg::S_IDLE;
    else     state <= state_next;
  end

  hcd_ram #(.WIDTH(hcd_pkg::PIX_W), .DEPTH(hcd_pkg::RAM_DEPTH)) u_pix_ram (
    .clk(clk), .we(pix_we), .waddr(pix_waddr), .wdata(pix),
    .raddr(rd_addr), .rdata(pix_rdata)
  );

  hcd_ram #(.WIDTH(hcd_pkg::GPAIR_W), .DEPTH(hcd_pkg::RAM_DEPTH)) u_grad_ram (
    .clk(clk), .we(grad_we), .waddr(grad_waddr),
    .wdata({dx_acc[hcd_pkg::GRAD_W-1:0], dy_acc[hcd_pkg::GRAD_W-1:0]}),
    .raddr(rd_addr), .rdata(grad_rdata)
  );

  // Raster count and per-request control
  always_ff @(posedge clk) begin
    if (rst) begin
      k     <= '0;
      krow  <= '0;
      kcol  <= '0;
      glive <= 1'b0;
      wlive <= 1'b0;
      plive <= 1'b0;
    end else begin
      glive <= (state == hcd_pkg::S_GRD);
      wlive <= (state == hcd_pkg::S_WIN) && in_img;
      plive <= wlive;
      if (state == hcd_pkg::S_START && k >= frame_end) begin
        k    <= '0;
        krow <= '0;
        kcol <= '0;
      end else if (state == hcd_pkg::S_OUT && state_next == hcd_pkg::S_IDLE && !noadv) begin
        if (k + hcd_pkg::K_W'(1) >= frame_end) begin
          k    <= '0;
          krow <= '0;
          kcol <= '0;
        end else begin
          k <= k + hcd_pkg::K_W'(1);
          if (kcol + hcd_pkg::SIZE_W'(1) == wc) begin
            kcol <= '0;
            krow <= krow + hcd_pkg::SIZE_W'(1);
          end else begin
            kcol <= kcol + hcd_pkg::SIZE_W'(1);
          end
        end
      end
    end
  end

  // Sweep counters and tags
  always_ff @(posedge clk) begin
    ti <= wi;
    tj <= wj;
    if (state == hcd_pkg::S_CHK || state == hcd_pkg::S_GWR) begin
      wi <= '0;
      wj <= '0;
    end else if (state == hcd_pkg::S_GRD || state == hcd_pkg::S_WIN) begin
      if (wj == 2'd2) begin
        wj <= '0;
        wi <= wi + 2'd1;
      end else begin
        wj <= wj + 2'd1;
      end
    end
  end

  // Sobel accumulation, tensor sums and corner decision
  logic signed [11:0] pix_s, sx, sy;
  logic signed [GRAD_SW-1:0] gdx, gdy;
  localparam int GRAD_SW = hcd_pkg::GRAD_W;
  logic signed [25:0] am, cm;
  logic signed [55:0] resp, rt25;

  always_comb begin
    pix_s = $signed({4'b0000, pix_rdata});
    sx    = (ti == 2'd1) ? (pix_s <<< 1) : pix_s;
    sy    = (tj == 2'd1) ? (pix_s <<< 1) : pix_s;
    gdx   = $signed(grad_rdata[hcd_pkg::GPAIR_W-1:hcd_pkg::GRAD_W]);
    gdy   = $signed(grad_rdata[hcd_pkg::GRAD_W-1:0]);
    am    = $signed({2'b00, a_acc}) - $signed({2'b00, thr_e});
    cm    = $signed({2'b00, c_acc}) - $signed({2'b00, thr_e});
    // times 25, the inverse of K
    resp  = (det <<< 4) + (det <<< 3) + det - $signed({6'd0, trsq});
    rt25  = $signed({32'd0, thr_r} << 4) + $signed({32'd0, thr_r} << 3)
          + $signed({32'd0, thr_r});
  end

  always_ff @(posedge clk) begin
    if (state == hcd_pkg::S_IDLE && in_valid) begin
      func <= in_data.func;
      pix  <= in_data.pixel;
    end
    if (state == hcd_pkg::S_SETUP) begin
      total     <= hcd_pkg::K_W'(wc * hc);
      frame_end <= hcd_pkg::K_W'(wc * hc) + hcd_pkg::K_W'({wc, 1'b0}) + hcd_pkg::K_W'(2);
    end
    if (state == hcd_pkg::S_CHK) begin
      noadv    <= pix_due && (func == hcd_pkg::FUNC_DRAIN);
      res_live <= !(pix_due && (func == hcd_pkg::FUNC_DRAIN)) && qvalid;
      corner   <= 1'b0;
      dx_acc   <= '0;
      dy_acc   <= '0;
      a_acc    <= '0;
      c_acc    <= '0;
      b_acc    <= '0;
    end
    if (glive) begin
      if (tj == 2'd0) dx_acc <= dx_acc - sx;
      else if (tj == 2'd2) dx_acc <= dx_acc + sx;
      if (ti == 2'd0) dy_acc <= dy_acc - sy;
      else if (ti == 2'd2) dy_acc <= dy_acc + sy;
    end
    if (wlive) begin
      pxx <= gdx * gdx;
      pyy <= gdy * gdy;
      pxy <= gdx * gdy;
    end
    if (plive) begin
      a_acc <= a_acc + {2'b00, pxx};
      c_acc <= c_acc + {2'b00, pyy};
      b_acc <= b_acc + {{3{pxy[21]}}, pxy};
    end
    if (state == hcd_pkg::S_D1) begin
      pe <= am * cm;
      bb <= b_acc * b_acc;
      tr <= {1'b0, a_acc} + {1'b0, c_acc};
      t1 <= ({1'b0, a_acc} + {1'b0, c_acc}) > {thr_e, 1'b0};
    end
    if (state == hcd_pkg::S_D2) begin
      t2 <= pe > bb;
      ac <= a_acc * c_acc;
    end
    if (state == hcd_pkg::S_D3) begin
      det  <= $signed({8'd0, ac}) - {{4{bb[51]}}, bb};
      trsq <= tr * tr;
    end
    if (state == hcd_pkg::S_D4) begin
      corner <= t1 && t2 && (resp > rt25);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_data  <= '0;
    end else if (state == hcd_pkg::S_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
      if (res_live) begin
        out_data.valid_res <= 1'b1;
        out_data.row       <= qr[hcd_pkg::ROW_W-1:0];
        out_data.col       <= qc[hcd_pkg::COL_W-1:0];
        out_data.is_corner <= corner;
        out_data.last      <= (qr == h_s - PW'(1)) && (qc == w_s - PW'(1));
      end else begin
        out_data <= '0;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/core/hcd_checker.sv */
// Port-level checker for the Harris corner detector, bound to the top level.
module hcd_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input hcd_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input hcd_pkg::out_t out_data
);

  // One request in work at a time
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Undecided results carry zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.valid_res |->
      out_data.row == '0 && out_data.col == '0 && !out_data.is_corner && !out_data.last)
    else $error("undecided result with nonzero fields");

  // Frame end only on a decided position
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last |-> out_data.valid_res)
    else $error("frame end flagged on undecided result");

  // Reset empties the output
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind harris_corner_detector_top hcd_checker u_hcd_checker (.*);

/* test/hcd_result_checker.sv */
// Result checker for the Harris corner detector: watches both channels, predicts, compares.
module hcd_result_checker
  import hcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_t                   in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING = 2 * MAX_WIDTH + 4;

  // Shadow registers and line stores
  int unsigned   width_reg, height_reg, eigen_thr, resp_thr;
  logic [7:0]    pix_ring [RING];
  int            dx_ring [RING];
  int            dy_ring [RING];
  int unsigned   raster_pos;
  out_t          expected_results [$];

  function automatic int clamp_size(int unsigned v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return int'(hi);
    return int'(v);
  endfunction

  function automatic int mirror(int v, int n);
    if (v < 0) return 1;
    if (v >= n) return n - 2;
    return v;
  endfunction

  function automatic int pix(int r, int c, int w);
    return int'(pix_ring[(r * w + c) % RING]);
  endfunction

  // Sobel gradient for raster position g
  function automatic void build_gradient(int g, int w, int h);
    int r, c, ru, rd, cl, cr;
    r = g / w;
    c = g % w;
    ru = mirror(r - 1, h);
    rd = mirror(r + 1, h);
    cl = mirror(c - 1, w);
    cr = mirror(c + 1, w);
    dx_ring[g % RING] = (pix(ru, cr, w) - pix(ru, cl, w))
                      + 2 * (pix(r, cr, w) - pix(r, cl, w))
                      + (pix(rd, cr, w) - pix(rd, cl, w));
    dy_ring[g % RING] = (pix(rd, cl, w) - pix(ru, cl, w))
                      + 2 * (pix(rd, c, w) - pix(ru, c, w))
                      + (pix(rd, cr, w) - pix(ru, cr, w));
  endfunction

  // Structure tensor over the 3x3 window, then eigen and response tests
  function automatic bit corner_at(int q, int w, int h);
    int r, c, idx;
    longint a, b, cc, t, rt, det, tr;
    r = q / w;
    c = q % w;
    a = 0;
    b = 0;
    cc = 0;
    for (int i = r - 1; i <= r + 1; i++) begin
      for (int j = c - 1; j <= c + 1; j++) begin
        if (i < 0 || j < 0 || i >= h || j >= w) continue;
        idx = (i * w + j) % RING;
        a  += longint'(dx_ring[idx]) * dx_ring[idx];
        cc += longint'(dy_ring[idx]) * dy_ring[idx];
        b  += longint'(dx_ring[idx]) * dy_ring[idx];
      end
    end
    t = longint'(eigen_thr);
    rt = longint'(resp_thr);
    if (!(a + cc > 2 * t)) return 0;
    if (!((a - t) * (cc - t) > b * b)) return 0;
    det = a * cc - b * b;
    tr = a + cc;
    return (25 * det - tr * tr > 25 * rt);
  endfunction

  // One accepted request: update the shadow state, queue the expected result
  function automatic void predict_pixel_result(logic f, logic [7:0] p);
    int w, h, total, fend, k, g, q;
    out_t res;
    w = clamp_size(width_reg, MAX_WIDTH);
    h = clamp_size(height_reg, MAX_HEIGHT);
    total = w * h;
    fend = total + 2 * w + 2;
    res = '0;
    if (raster_pos >= fend) raster_pos = 0;
    k = int'(raster_pos);
    if (k < total) begin
      if (f == FUNC_DRAIN) begin
        expected_results.push_back(res);
        return;
      end
      pix_ring[k % RING] = p;
    end
    g = k - (w + 1);
    if (g >= 0 && g < total) build_gradient(g, w, h);
    q = k - (2 * w + 2);
    if (q >= 0 && q < total) begin
      res.valid_res = 1'b1;
      res.row = ROW_W'(q / w);
      res.col = COL_W'(q % w);
      res.is_corner = corner_at(q, w, h);
      res.last = (q == total - 1);
    end
    raster_pos = (k + 1 >= fend) ? 0 : k + 1;
    expected_results.push_back(res);
  endfunction

  function automatic void report(string field, int exp_v, int act_v);
    $display("%0t mismatch %s: expected %0d actual %0d", $time, field, exp_v, act_v);
    errors++;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      width_reg = 640;
      height_reg = 480;
      eigen_thr = 183400;
      resp_thr = 183400;
      raster_pos = 0;
      foreach (pix_ring[i]) begin
        pix_ring[i] = '0;
        dx_ring[i] = 0;
        dy_ring[i] = 0;
      end
      expected_results.delete();
      errors = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  width_reg  = cfg_data & 24'h7FF;
          REG_FRAME_HEIGHT: height_reg = cfg_data & 24'h7FF;
          REG_EIGEN_THR:    eigen_thr  = cfg_data;
          REG_RESP_THR:     resp_thr   = cfg_data;
          default: ;
        endcase
      end
      // result side: compare against the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result: actual %p", $time, out_data);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (want.valid_res !== out_data.valid_res)
            report("valid_res", want.valid_res, out_data.valid_res);
          if (want.row !== out_data.row) report("row", want.row, out_data.row);
          if (want.col !== out_data.col) report("col", want.col, out_data.col);
          if (want.is_corner !== out_data.is_corner)
            report("is_corner", want.is_corner, out_data.is_corner);
          if (want.last !== out_data.last) report("last", want.last, out_data.last);
        end
      end
      // request side
      if (in_valid && in_ready) predict_pixel_result(in_data.func, in_data.pixel);
    end
    pending = expected_results.size();
  end

endmodule

/* test/harris_corner_detector_top_test.sv */
// Stimulus and verdict for the Harris corner detector top level.
module harris_corner_detector_top_test;
  import hcd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int TARGET_ITEMS = 1000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int   errors;
  int   pending;
  int   cycles = 0;
  int   item_count = 0;
  bit   calm = 0;
  bit   hold_long = 0;

  always #10 clk = ~clk;

  harris_corner_detector_top u_dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_data
  );

  hcd_result_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_data, .errors, .pending
  );

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL harris_corner_detector_top");
      $finish;
    end
  end

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_long = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Send one request; valid stays up between back-to-back requests
  task automatic send_request(logic f, logic [7:0] p);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.func = f;
    in_data.pixel = p;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic int unsigned pick_threshold();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 24'hFFFFFF;
      2: return $urandom_range(0, 200000);
      3: return 183400;
      default: return $urandom & 24'hFFFFFF;
    endcase
  endfunction

  // One frame: pixels with stray early drains, then the flush with stray pixels.
  // style 0 = noise, 1 = 0/255 checkerboard, 2 = 2x2 blocks with noise
  task automatic run_frame(int unsigned wr, int unsigned hr, int style, bit forced);
    int w, h, total;
    logic [7:0] p;
    w = (wr < 3) ? 3 : (wr > MAX_WIDTH) ? MAX_WIDTH : int'(wr);
    h = (hr < 3) ? 3 : (hr > MAX_HEIGHT) ? MAX_HEIGHT : int'(hr);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, wr);
    write_reg(REG_FRAME_HEIGHT, hr);
    total = w * h;
    for (int i = 0; i < total; i++) begin
      if ((forced && i == total / 2) || $urandom_range(0, 31) == 0)
        send_request(FUNC_DRAIN, 8'($urandom));
      case (style)
        1: p = (((i / w) + (i % w)) % 2 != 0) ? 8'd255 : 8'd0;
        2: p = ((((i / w) >> 1) ^ ((i % w) >> 1)) & 1) ? 8'($urandom_range(200, 255))
                                                         : 8'($urandom_range(0, 55));
        default: p = 8'($urandom);
      endcase
      send_request(FUNC_PIXEL, p);
      item_count++;
    end
    for (int j = 0; j < 2 * w + 2; j++) begin
      if ((forced && j == 0) || $urandom_range(0, 3) == 0)
        send_request(FUNC_PIXEL, 8'($urandom));
      else
        send_request(FUNC_DRAIN, 8'($urandom));
      item_count++;
    end
  endtask

  initial begin
    int frame_no;
    repeat (8) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed: smallest frame with reset thresholds, then zero and max thresholds
    run_frame(3, 3, 1, 1);
    run_frame(0, 2, 2, 1);
    wait_idle();
    write_reg(REG_EIGEN_THR, 0);
    write_reg(REG_RESP_THR, 0);
    run_frame(3, 3, 1, 1);
    wait_idle();
    write_reg(REG_EIGEN_THR, 24'hFFFFFF);
    write_reg(REG_RESP_THR, 24'hFFFFFF);
    run_frame(4, 3, 2, 1);

    // Random frames of small sizes
    frame_no = 0;
    while (item_count < TARGET_ITEMS) begin
      wait_idle();
      write_reg(REG_EIGEN_THR, pick_threshold());
      write_reg(REG_RESP_THR, pick_threshold());
      if (frame_no == 3) hold_long = 1;
      if (item_count > 850) calm = 1;
      run_frame($urandom_range(1, 9), $urandom_range(1, 9), $urandom_range(0, 2), 0);
      frame_no++;
    end

    // Largest sizes, kept short in the other dimension
    calm = 0;
    wait_idle();
    write_reg(REG_EIGEN_THR, $urandom_range(0, 200000));
    write_reg(REG_RESP_THR, $urandom_range(0, 200000));
    run_frame(2047, 3, 2, 0);
    run_frame(3, 1024, 0, 0);
    calm = 1;
    run_frame(1024, 3, 2, 0);
    run_frame(5, 5, 1, 0);

    wait_idle();
    if (errors == 0) begin
      $display("PASS harris_corner_detector_top");
    end else begin
      $display("FAIL harris_corner_detector_top");
    end
    $finish;
  end

endmodule
